@@ sv/inverted_index_builder_defines.svh @@
// Assertion macros for the inverted index builder.
`ifndef INVERTED_INDEX_BUILDER_DEFINES_SVH
`define INVERTED_INDEX_BUILDER_DEFINES_SVH
`ifndef SYNTH
`define IIB_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define IIB_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define IIB_ASSERT_IMP(label, clk, rst, a, c)
`define IIB_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

@@ sv/iib_pkg.sv @@
// Package with shared types and constants of the inverted index builder.
package iib_pkg;
  localparam int MaxEntries   = 4096;
  localparam int ElementRange = 1024;
  localparam int PatchRange   = 4096;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_BUILD  = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_PHASE = 2'd3;

  // Datapath commands for the controller phases; CMD_RESP is not issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE, CMD_EXEC, CMD_RESP, CMD_CLR, CMD_COUNT, CMD_SCAN, CMD_SCATTER, CMD_SORT
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic start;
  } ctl_t;

  typedef struct packed {
    logic done;
  } sts_t;
endpackage

@@ sv/iib_datapath.sv @@
// Datapath of the inverted index builder: stores, build sweeps and result forming.
module iib_datapath import iib_pkg::*; #(
  parameter int MAX_ENTRIES   = MaxEntries,
  parameter int ELEMENT_RANGE = ElementRange,
  parameter int PATCH_RANGE   = PatchRange
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  output sts_t        sts,
  output logic        built,
  input  logic [10:0] element_limit,
  input  logic [2:0]  operation,
  input  logic [9:0]  element_id,
  input  logic [11:0] patch_id,
  input  logic [11:0] position,
  output logic [1:0]  status,
  output logic        found,
  output logic [12:0] start_offset,
  output logic [12:0] list_count,
  output logic [11:0] patch_out,
  output logic [10:0] key_count
);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int EW = $clog2(ELEMENT_RANGE);
  localparam int CW = AW + 1;

  logic [EW-1:0] pair_elements [MAX_ENTRIES];
  logic [11:0]   pair_owners   [MAX_ENTRIES];
  logic [11:0]   entry_patches [MAX_ENTRIES];
  logic [CW-1:0] element_counts [ELEMENT_RANGE];
  logic [CW-1:0] list_offsets   [ELEMENT_RANGE];
  logic [CW-1:0] fill_cursor    [ELEMENT_RANGE];

  logic [CW-1:0] pair_total;
  logic [10:0]   distinct_keys;
  logic          index_built;

  // Sweep state.
  logic [CW-1:0] idx;
  logic [1:0]    ph;
  logic [EW-1:0] pe;
  logic [11:0]   po;
  logic [CW-1:0] rc, rs, sum;
  logic [CW-1:0] ia, ib, lo, hi;
  logic [11:0]   va, vb;

  // Latched item.
  logic [2:0]  op_q;
  logic [9:0]  el_q;
  logic [11:0] pa_q;
  logic [11:0] po_q;
  logic [12:0] rcnt, roff;
  logic [11:0] rpatch;
  logic [1:0]  st_q;

  logic el_bad;
  assign el_bad = ({1'b0, el_q} >= element_limit) || (32'(el_q) >= ELEMENT_RANGE);
  assign built = index_built;

  always_ff @(posedge clk) begin
    sts.done <= 1'b0;
    if (rst) begin
      pair_total <= '0; distinct_keys <= '0; index_built <= 1'b0;
      idx <= '0; ph <= '0;
    end else begin
      if (ctl.start) begin
        idx <= '0; ph <= '0; sum <= '0; distinct_keys <= '0;
        op_q <= operation; el_q <= element_id; pa_q <= patch_id; po_q <= position;
      end
      // The controller sees done in the cycle after it is set; the datapath does nothing while done is high.
      if (!sts.done) begin
        unique case (ctl.cmd)
          CMD_EXEC: begin
            // Registered reads for lookup and read.
            rcnt <= 13'(element_counts[el_q[EW-1:0]]);
            roff <= 13'(list_offsets[el_q[EW-1:0]]);
            rpatch <= entry_patches[po_q[AW-1:0]];
            // Append and build status come from the state before this step.
            st_q <= ST_OK;
            if (op_q == OP_APPEND) begin
              if (index_built) st_q <= ST_PHASE;
              else if (32'(pair_total) >= MAX_ENTRIES) st_q <= ST_FULL;
              else if (el_bad) st_q <= ST_RANGE;
              else if (32'(pa_q) >= PATCH_RANGE) st_q <= ST_PHASE;
            end else if (op_q == OP_BUILD && index_built) begin
              st_q <= ST_PHASE;
            end
            if (op_q == OP_APPEND && !index_built && 32'(pair_total) < MAX_ENTRIES
                && !el_bad && 32'(pa_q) < PATCH_RANGE) begin
              pair_elements[pair_total[AW-1:0]] <= el_q[EW-1:0];
              pair_owners[pair_total[AW-1:0]] <= pa_q;
              pair_total <= pair_total + 1'b1;
            end
            if (op_q == OP_CLEAR) begin
              pair_total <= '0; distinct_keys <= '0; index_built <= 1'b0;
            end
          end
          CMD_CLR: begin
            element_counts[idx[EW-1:0]] <= '0;
            if (32'(idx) == ELEMENT_RANGE - 1) begin idx <= '0; sts.done <= 1'b1; end
            else idx <= idx + 1'b1;
          end
          CMD_COUNT: begin
            // Per pair: read the pair, read its count, then bump it.
            if (ph == 2'd0) begin
              if (idx == pair_total) begin idx <= '0; sts.done <= 1'b1; end
              else begin pe <= pair_elements[idx[AW-1:0]]; ph <= 2'd1; end
            end else if (ph == 2'd1) begin
              rc <= element_counts[pe]; ph <= 2'd2;
            end else begin
              element_counts[pe] <= rc + 1'b1; idx <= idx + 1'b1; ph <= 2'd0;
            end
          end
          CMD_SCAN: begin
            if (ph == 2'd0) begin
              rs <= element_counts[idx[EW-1:0]]; ph <= 2'd1;
            end else begin
              list_offsets[idx[EW-1:0]] <= sum;
              fill_cursor[idx[EW-1:0]] <= sum;
              sum <= sum + rs;
              if (rs != '0) distinct_keys <= distinct_keys + 1'b1;
              ph <= 2'd0;
              if (32'(idx) == ELEMENT_RANGE - 1) begin idx <= '0; sts.done <= 1'b1; end
              else idx <= idx + 1'b1;
            end
          end
          CMD_SCATTER: begin
            if (ph == 2'd0) begin
              if (idx == pair_total) begin idx <= '0; sts.done <= 1'b1; end
              else begin
                pe <= pair_elements[idx[AW-1:0]]; po <= pair_owners[idx[AW-1:0]];
                ph <= 2'd1;
              end
            end else if (ph == 2'd1) begin
              rc <= fill_cursor[pe]; ph <= 2'd2;
            end else begin
              entry_patches[rc[AW-1:0]] <= po;
              fill_cursor[pe] <= rc + 1'b1;
              idx <= idx + 1'b1; ph <= 2'd0;
            end
          end
          CMD_SORT: begin
            // Per element insertion sort, one compare and move per step.
            unique case (ph)
              2'd0: begin
                if (32'(idx) == ELEMENT_RANGE) begin
                  index_built <= 1'b1; sts.done <= 1'b1;
                end else begin
                  lo <= list_offsets[idx[EW-1:0]];
                  hi <= list_offsets[idx[EW-1:0]] + element_counts[idx[EW-1:0]];
                  ia <= list_offsets[idx[EW-1:0]] + 1'b1;
                  ph <= 2'd1;
                end
              end
              2'd1: begin
                if (ia >= hi) begin idx <= idx + 1'b1; ph <= 2'd0; end
                else begin
                  va <= entry_patches[ia[AW-1:0]]; ib <= ia; ph <= 2'd2;
                end
              end
              2'd2: begin
                vb <= entry_patches[ib[AW-1:0] - 1'b1]; ph <= 2'd3;
              end
              default: begin
                if (ib > lo && vb > va) begin
                  entry_patches[ib[AW-1:0]] <= vb;
                  ib <= ib - 1'b1;
                  // At the group start the next step only places the value.
                  if (ib - 1'b1 > lo) ph <= 2'd2;
                end else begin
                  entry_patches[ib[AW-1:0]] <= va; ia <= ia + 1'b1; ph <= 2'd1;
                end
              end
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  // Result forming from the latched item, the status registered in EXEC and the current index state.
  logic [1:0] st;
  always_comb begin
    st = ST_OK; found = 1'b0; start_offset = '0; list_count = '0;
    patch_out = '0; key_count = '0;
    case (op_q)
      OP_APPEND: st = st_q;
      OP_BUILD: begin
        st = st_q;
        if (st_q == ST_OK) key_count = distinct_keys;
      end
      OP_LOOKUP: begin
        if (!index_built) st = ST_PHASE;
        else if (el_bad) st = ST_RANGE;
        else if (rcnt != '0) begin
          found = 1'b1; start_offset = roff; list_count = rcnt;
        end
      end
      OP_READ: begin
        if (!index_built || {1'b0, po_q} >= 13'(pair_total)) st = ST_PHASE;
        else patch_out = rpatch;
      end
      OP_CLEAR: ;
      default: st = ST_PHASE;
    endcase
    status = st;
  end
endmodule

@@ sv/iib_ctrl.sv @@
// Controller state machine of the inverted index builder.
module iib_ctrl import iib_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  operation,
  input  logic        built,
  input  sts_t        sts,
  output ctl_t        ctl,
  output logic        load,
  output logic        m_tvalid,
  input  logic        m_tready
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_EXEC = 8'b00000010, S_CLR = 8'b00000100,
    S_COUNT = 8'b00001000, S_SCAN = 8'b00010000, S_SCAT = 8'b00100000,
    S_SORT = 8'b01000000, S_OUT = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic [2:0] op_q;
  logic bld_ok;

  assign s_tready = (state == S_IDLE);
  // The output register takes a new result once the previous one has left.
  assign load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    ctl.cmd = CMD_NONE;
    ctl.start = s_tvalid && s_tready;
    unique case (state)
      S_IDLE: if (s_tvalid && s_tready) state_next = S_EXEC;
      S_EXEC: begin
        ctl.cmd = CMD_EXEC;
        state_next = (op_q == OP_BUILD && bld_ok) ? S_CLR : S_OUT;
      end
      S_CLR:   begin ctl.cmd = CMD_CLR;     if (sts.done) state_next = S_COUNT; end
      S_COUNT: begin ctl.cmd = CMD_COUNT;   if (sts.done) state_next = S_SCAN; end
      S_SCAN:  begin ctl.cmd = CMD_SCAN;    if (sts.done) state_next = S_SCAT; end
      S_SCAT:  begin ctl.cmd = CMD_SCATTER; if (sts.done) state_next = S_SORT; end
      S_SORT:  begin ctl.cmd = CMD_SORT;    if (sts.done) state_next = S_OUT; end
      S_OUT:   if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (s_tvalid && s_tready) begin op_q <= operation; bld_ok <= !built; end
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end
endmodule

@@ sv/inverted_index_builder.sv @@
// Top level of the inverted index builder.
// Builds an inverted index (CSR transpose) from appended (element, patch) pairs.
// Input items arrive on s_tvalid/s_tready/s_tdata; one transaction is one item.
// Each item gives exactly one result on m_tvalid/m_tready/m_tdata.
// Append, lookup, read, clear: the item is latched, executed in the EXEC state
// and its result is loaded into the output register from the OUT state.
// Build: runs the clear, count, scan, scatter and sort sweeps in that order
// over the single port stores before its result is loaded.
// One item is processed at a time; the next item is taken while its
// predecessor's result waits in the output register.
// If the receiver stalls, the result holds on m_tdata until accepted, and a
// second item stalls the input once it has been processed.
// The element_limit register is written through cfg_valid/cfg_ready/cfg_data.
// Reset empties the store and index and sets element_limit to 1024.
// Clear returns all state to reset but keeps element_limit.
// Store contents that were never written are not cleared by reset.
module inverted_index_builder import iib_pkg::*; #(
  parameter int MAX_ENTRIES   = MaxEntries,
  parameter int ELEMENT_RANGE = ElementRange,
  parameter int PATCH_RANGE   = PatchRange
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // operation, element_id, patch_id, position
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // status, found, start_offset, list_count, patch_out, key_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);
`include "inverted_index_builder_defines.svh"
  logic [10:0] element_limit;
  ctl_t ctl;
  sts_t sts;
  logic load;
  logic [1:0] status;
  logic found;
  logic [12:0] start_offset, list_count;
  logic [11:0] patch_out;
  logic [10:0] key_count;
  logic built;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) element_limit <= 11'd1024;
    else if (cfg_valid) element_limit <= cfg_data;
  end

  iib_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .operation(s_tdata[2:0]),
    .built, .sts, .ctl, .load,
    .m_tvalid, .m_tready
  );

  iib_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES), .ELEMENT_RANGE(ELEMENT_RANGE),
    .PATCH_RANGE(PATCH_RANGE)
  ) u_dp (
    .clk, .rst, .ctl, .sts, .built, .element_limit,
    .operation(s_tdata[2:0]), .element_id(s_tdata[12:3]),
    .patch_id(s_tdata[24:13]), .position(s_tdata[36:25]),
    .status, .found, .start_offset, .list_count, .patch_out, .key_count
  );

  always_ff @(posedge clk) begin
    if (rst) m_tdata <= '0;
    else if (load) begin
      m_tdata <= {4'd0, key_count, patch_out, list_count, start_offset, found, status};
    end
  end

  `IIB_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `IIB_ASSERT_NXT(a_acc_busy, clk, rst, s_tvalid && s_tready, !s_tready)
  `IIB_ASSERT_IMP(a_ok_fields, clk, rst, m_tvalid && m_tdata[1:0] != ST_OK, m_tdata[2] == 1'b0)
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the inverted index builder stream interface.
`timescale 1ns / 1ps

module tb;
  import iib_pkg::*;

  localparam logic [2:0] OP_UNUSED5 = 3'd5;
  localparam logic [2:0] OP_UNUSED6 = 3'd6;
  localparam logic [2:0] OP_UNUSED7 = 3'd7;
  localparam int CycleLimit = 1500000;
  localparam int HoldCycles = 600;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [12:0] start_offset;
    logic [12:0] list_count;
    logic [11:0] patch_out;
    logic [10:0] key_count;
  } reply_t;

  // Mirror of the index state; computes the reply for every accepted command.
  class index_scoreboard;
    bit [9:0]  pair_elem[MaxEntries];
    bit [11:0] pair_patch[MaxEntries];
    int        elem_count[ElementRange];
    int        elem_offset[ElementRange+1];
    bit [11:0] entries[MaxEntries];
    int        pairs;
    int        keys;
    bit        built;
    int        limit;
    reply_t    pending_q[$];
    int        mismatches;

    function new();
      limit = 1024;
      wipe();
    endfunction

    function void wipe();
      foreach (elem_count[i]) elem_count[i] = 0;
      pairs = 0;
      keys = 0;
      built = 0;
    endfunction

    function void build();
      int fill[ElementRange];
      int sum;
      int b;
      bit [11:0] v;
      sum = 0;
      foreach (elem_count[i]) elem_count[i] = 0;
      for (int i = 0; i < pairs; i++) elem_count[pair_elem[i]]++;
      keys = 0;
      for (int e = 0; e < ElementRange; e++) begin
        elem_offset[e] = sum;
        fill[e] = sum;
        sum += elem_count[e];
        if (elem_count[e] != 0) keys++;
      end
      elem_offset[ElementRange] = sum;
      for (int i = 0; i < pairs; i++) begin
        entries[fill[pair_elem[i]]] = pair_patch[i];
        fill[pair_elem[i]]++;
      end
      // Insertion sort inside each element's group.
      for (int e = 0; e < ElementRange; e++) begin
        for (int a = elem_offset[e] + 1; a < elem_offset[e+1]; a++) begin
          v = entries[a];
          b = a;
          while (b > elem_offset[e] && entries[b-1] > v) begin
            entries[b] = entries[b-1];
            b--;
          end
          entries[b] = v;
        end
      end
      built = 1;
    endfunction

    function void note(logic [2:0] op, logic [9:0] elem, logic [11:0] patch,
                       logic [11:0] pos);
      reply_t r;
      r = '0;
      case (op)
        OP_APPEND: begin
          if (built) r.status = ST_PHASE;
          else if (pairs >= MaxEntries) r.status = ST_FULL;
          else if (elem >= limit) r.status = ST_RANGE;
          else begin
            pair_elem[pairs] = elem;
            pair_patch[pairs] = patch;
            pairs++;
          end
        end
        OP_BUILD: begin
          if (built) r.status = ST_PHASE;
          else begin
            build();
            r.key_count = 11'(keys);
          end
        end
        OP_LOOKUP: begin
          if (!built) r.status = ST_PHASE;
          else if (elem >= limit) r.status = ST_RANGE;
          else if (elem_count[elem] != 0) begin
            r.found = 1'b1;
            r.start_offset = 13'(elem_offset[elem]);
            r.list_count = 13'(elem_count[elem]);
          end
        end
        OP_READ: begin
          if (!built || pos >= pairs) r.status = ST_PHASE;
          else r.patch_out = entries[pos];
        end
        OP_CLEAR: wipe();
        default: r.status = ST_PHASE;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check(logic [55:0] data);
      reply_t got;
      reply_t exp;
      got = reply_t'{data[1:0], data[2], data[15:3], data[28:16], data[40:29], data[51:41]};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", data);
        return;
      end
      exp = pending_q.pop_front();
      if (got.status !== exp.status || got.found !== exp.found ||
          got.start_offset !== exp.start_offset || got.list_count !== exp.list_count ||
          got.patch_out !== exp.patch_out || got.key_count !== exp.key_count ||
          data[55:52] !== 4'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp st=%0d f=%0d so=%0d lc=%0d po=%0d kc=%0d,",
                    " got st=%0d f=%0d so=%0d lc=%0d po=%0d kc=%0d"},
                   exp.status, exp.found, exp.start_offset, exp.list_count, exp.patch_out,
                   exp.key_count, got.status, got.found, got.start_offset, got.list_count,
                   got.patch_out, got.key_count);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;

  index_scoreboard sb;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int cycles = 0;

  inverted_index_builder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata);
  end

  // Receiver side: random stalls, plus one long hold-off once requested.
  initial begin
    int held;
    held = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && held < HoldCycles) begin
        m_tready = 1'b0;
        held++;
      end else begin
        m_tready = no_idle ? 1'b1 : ($urandom_range(99) >= 31);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_cmd(logic [2:0] op, logic [9:0] elem, logic [11:0] patch,
                          logic [11:0] pos);
    while (!no_idle && $urandom_range(99) < 31) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {3'd0, pos, patch, elem, op};
    do @(posedge clk); while (!s_tready);
    sb.note(op, elem, patch, pos);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_limit(logic [10:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    sb.limit = int'(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_noise();
    logic [2:0] op;
    op = 3'($urandom_range(7));
    send_cmd(op, 10'($urandom), 12'($urandom), 12'($urandom));
  endtask

  // One load/build/query round with mostly well-formed traffic.
  task automatic random_round(int n_pairs, int n_queries);
    int pch;
    int lim;
    lim = (sb.limit < ElementRange) ? sb.limit : ElementRange;
    send_cmd(OP_CLEAR, 10'($urandom), 12'($urandom), 12'($urandom));
    pch = $urandom_range(200);
    for (int i = 0; i < n_pairs; i++) begin
      if ($urandom_range(9) == 0) random_noise();
      if ($urandom_range(7) == 0) pch = $urandom_range(4095);
      else if (pch < 4095) pch += $urandom_range(3);
      if (pch > 4095) pch = 4095;
      send_cmd(OP_APPEND, 10'((lim > 16 && $urandom_range(1)) ? $urandom_range(15) :
               $urandom_range(lim - 1)), 12'(pch), 12'($urandom));
    end
    send_cmd(OP_BUILD, 10'($urandom), 12'($urandom), 12'($urandom));
    for (int i = 0; i < n_queries; i++) begin
      case ($urandom_range(9))
        0: random_noise();
        1, 2, 3, 4: send_cmd(OP_LOOKUP,
                             10'($urandom_range(1) ? $urandom_range(15) : $urandom),
                             12'($urandom), 12'($urandom));
        default: send_cmd(OP_READ, 10'($urandom), 12'($urandom),
                          12'($urandom_range(3) ? $urandom_range(n_pairs) : $urandom));
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corner cases.
    send_cmd(OP_READ, 10'd0, 12'd0, 12'd0);
    send_cmd(OP_LOOKUP, 10'd0, 12'd0, 12'd0);
    send_cmd(OP_UNUSED5, 10'h3ff, 12'hfff, 12'hfff);
    send_cmd(OP_UNUSED6, 10'd0, 12'd0, 12'd0);
    send_cmd(OP_UNUSED7, 10'h155, 12'haaa, 12'h555);
    send_cmd(OP_APPEND, 10'd1023, 12'd4095, 12'd0);
    send_cmd(OP_APPEND, 10'd0, 12'd0, 12'hfff);
    send_cmd(OP_APPEND, 10'd5, 12'd100, 12'd0);
    send_cmd(OP_APPEND, 10'd5, 12'd50, 12'd0);
    send_cmd(OP_BUILD, 10'd0, 12'd0, 12'd0);
    send_cmd(OP_BUILD, 10'd0, 12'd0, 12'd0);
    send_cmd(OP_APPEND, 10'd1, 12'd1, 12'd0);
    send_cmd(OP_LOOKUP, 10'd1023, 12'd0, 12'd0);
    send_cmd(OP_LOOKUP, 10'd5, 12'd0, 12'd0);
    send_cmd(OP_LOOKUP, 10'd7, 12'd0, 12'd0);
    send_cmd(OP_READ, 10'd0, 12'd0, 12'd1);
    send_cmd(OP_READ, 10'd0, 12'd0, 12'd4);
    send_cmd(OP_READ, 10'd0, 12'd0, 12'd4095);
    send_cmd(OP_CLEAR, 10'd0, 12'd0, 12'd0);
    send_cmd(OP_BUILD, 10'd0, 12'd0, 12'd0);
    send_cmd(OP_LOOKUP, 10'd0, 12'd0, 12'd0);
    set_limit(11'd1);
    send_cmd(OP_CLEAR, 10'd0, 12'd0, 12'd0);
    send_cmd(OP_APPEND, 10'd1, 12'd3, 12'd0);
    send_cmd(OP_APPEND, 10'd0, 12'd3, 12'd0);
    send_cmd(OP_BUILD, 10'd0, 12'd0, 12'd0);
    send_cmd(OP_LOOKUP, 10'd1, 12'd0, 12'd0);

    // Random rounds under several limits, with a stall-free stretch.
    for (int r = 0; r < 20; r++) begin
      if (r % 4 == 0) begin
        case (r / 4)
          0: set_limit(11'd1024);
          1: set_limit(11'd16);
          2: set_limit(11'd1);
          3: set_limit(11'd700);
          default: set_limit(11'($urandom_range(1024, 1)));
        endcase
      end
      no_idle = (r >= 8 && r < 11);
      if (r == 5) hold_req = 1'b1;
      random_round($urandom_range(40), $urandom_range(20, 5));
    end
    no_idle = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
